// File: rtl/cpt_pkg.sv
// shared constants, codes and types of the cascaded prescaled timer block
`default_nettype none

package cpt_pkg;

    // block configuration
    localparam int NUM_TIMERS      = 4;
    localparam int MAX_STEP_CYCLES = 64;

    // field widths
    localparam int SEL_W  = 2;
    localparam int CMD_W  = 2;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 16;
    localparam int CTRL_W = 8;
    localparam int CYC_W  = 7;
    localparam int ACC_W  = 11;
    localparam int IRQ_W  = 4;
    localparam int SLOTS  = 1 << SEL_W;

    // saturation limit of a tick, within what the cycle field can carry
    localparam int CYC_TOP = (1 << CYC_W) - 1;
    localparam logic [CYC_W-1:0] CYC_LIMIT =
        CYC_W'((MAX_STEP_CYCLES > CYC_TOP) ? CYC_TOP : MAX_STEP_CYCLES);

    // control word layout
    localparam logic [CTRL_W-1:0] CTRL_MASK = 8'hC7;
    localparam int CTRL_EN_BIT   = 7;
    localparam int CTRL_IRQ_BIT  = 6;
    localparam int CTRL_CASC_BIT = 2;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CONTROL = 2'd2;

    // classified operations passed through the queue
    typedef logic [1:0] op_t;
    localparam op_t OP_TICK    = 2'd0;
    localparam op_t OP_RELOAD  = 2'd1;
    localparam op_t OP_CONTROL = 2'd2;
    localparam op_t OP_REPORT  = 2'd3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        op_t              op;
        logic [SEL_W-1:0] sel;
        logic             sel_ok;
        logic [VAL_W-1:0] value;
        logic [CYC_W-1:0] cycles;
    } item_t;

    // iterative divider for long overflow runs
    localparam int DIV_W = ACC_W;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

    // prescale select to shift amount (shift of 0, 6, 8 or 10 bits)
    function automatic logic [3:0] prescale_shift(input logic [1:0] ps);
        logic [3:0] sh;
        begin
            case (ps)
                2'd0:    sh = 4'd0;
                2'd1:    sh = 4'd6;
                2'd2:    sh = 4'd8;
                default: sh = 4'd10;
            endcase
            return sh;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/cpt_front.sv
// front end: accepts input beats, classifies them and queues them for the back end
`default_nettype none

module cpt_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic [cpt_pkg::CMD_W-1:0]  command,
    input  wire logic [cpt_pkg::SEL_W-1:0]  timer_select,
    input  wire logic [cpt_pkg::VAL_W-1:0]  write_value,
    input  wire logic [cpt_pkg::CYC_W-1:0]  cycle_count,
    output logic                            q_valid,
    output cpt_pkg::item_t                  q_item,
    input  wire logic                       q_pop
);
    import cpt_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [CYC_W-1:0]  cyc_sat;
    logic              sel_ok;
    item_t             item_new;
    logic              push;
    logic              pop;

    item_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    // timer index check and tick saturation
    assign sel_ok  = ({1'b0, timer_select} < (SEL_W + 1)'(NUM_TIMERS));
    assign cyc_sat = (cycle_count > CYC_LIMIT) ? CYC_LIMIT : cycle_count;

    // classify: writes to a missing timer, empty ticks and the unused command code only report
    always_comb
    begin
        item_new.sel    = timer_select;
        item_new.sel_ok = sel_ok;
        item_new.value  = write_value;
        item_new.cycles = cyc_sat;
        item_new.op     = OP_REPORT;
        unique case (command)
            CMD_TICK:
            begin
                if (cyc_sat != '0)
                begin
                    item_new.op = OP_TICK;
                end
            end
            CMD_RELOAD:
            begin
                if (sel_ok)
                begin
                    item_new.op = OP_RELOAD;
                end
            end
            CMD_CONTROL:
            begin
                if (sel_ok)
                begin
                    item_new.op = OP_CONTROL;
                end
            end
            default:
            begin
                item_new.op = OP_REPORT;
            end
        endcase
    end

    // queue handshake
    assign item_stall = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign q_valid    = (fill_reg != '0);
    assign q_item     = q_mem[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign pop        = q_pop && q_valid;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item_new;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cpt_div.sv
// restoring divider, one quotient bit per cycle, for overflow runs of a timer
`default_nettype none

module cpt_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cpt_pkg::div_req_t  req,
    output cpt_pkg::div_rsp_t       rsp
);
    import cpt_pkg::*;

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  quo_next;
    logic [DIV_W-1:0]  dvs_reg;
    logic [DIV_W-1:0]  dvs_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              done_reg;
    logic              done_next;

    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              fits;

    // one trial subtraction
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        done_next = (step_reg == STEP_W'(1));
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            step_next = STEP_W'(DIV_W);
        end
        else if (step_reg != '0)
        begin
            rem_next  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = (step_reg != '0);
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/cpt_back.sv
// back end: timer state, write handling, tick sequencer and result register
`default_nettype none

module cpt_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       q_valid,
    input  wire cpt_pkg::item_t             q_item,
    output logic                            q_pop,
    output cpt_pkg::div_req_t               div_req,
    input  wire cpt_pkg::div_rsp_t          div_rsp,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [cpt_pkg::CNT_W-1:0]       counter_value,
    output logic [cpt_pkg::CTRL_W-1:0]      control_value,
    output logic [cpt_pkg::IRQ_W-1:0]       irq_raised
);
    import cpt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_INC   = 3'd2;
    localparam logic [2:0] ST_APPLY = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int          W1   = CNT_W + 1;
    localparam logic [W1-1:0] WRAP = {1'b1, {CNT_W{1'b0}}};

    // timer state
    logic [CNT_W-1:0]  count_reg  [SLOTS];
    logic [CNT_W-1:0]  reload_reg [SLOTS];
    logic [CTRL_W-1:0] ctrl_reg   [SLOTS];
    logic [ACC_W-1:0]  accum_reg  [SLOTS];

    // sequencer
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    item_t             item_reg;
    item_t             item_next;
    logic [SEL_W-1:0]  t_reg;
    logic [SEL_W-1:0]  t_next;
    logic [ACC_W-1:0]  inc_reg;
    logic [ACC_W-1:0]  inc_next;
    logic [ACC_W-1:0]  below_reg;
    logic [ACC_W-1:0]  below_next;
    logic [IRQ_W-1:0]  irq_reg;
    logic [IRQ_W-1:0]  irq_next;

    // result register
    logic              result_valid_reg;
    logic              result_valid_next;
    logic [CNT_W-1:0]  counter_value_reg;
    logic [CTRL_W-1:0] control_value_reg;
    logic [IRQ_W-1:0]  irq_raised_reg;

    // single access port into the timer state
    logic [SEL_W-1:0]  idx;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  cur_reload;
    logic [CTRL_W-1:0] cur_ctrl;
    logic [ACC_W-1:0]  cur_accum;
    logic              count_we;
    logic [CNT_W-1:0]  count_next;
    logic              reload_we;
    logic [CNT_W-1:0]  reload_next;
    logic              ctrl_we;
    logic [CTRL_W-1:0] ctrl_next;
    logic              accum_we;
    logic [ACC_W-1:0]  accum_next;

    // per-timer arithmetic
    logic [ACC_W-1:0]  acc_sum;
    logic [3:0]        shift;
    logic [W1-1:0]     to_wrap;
    logic [W1-1:0]     span;
    logic [W1-1:0]     inc_wide;
    logic [W1-1:0]     left;
    logic [ACC_W-1:0]  left_n;
    logic              cascaded;
    logic              finish;
    logic              advance;
    logic              out_load;
    logic [ACC_W-1:0]  ovf;

    assign idx = (state_reg == ST_INC || state_reg == ST_APPLY || state_reg == ST_DIV)
                 ? t_reg : item_reg.sel;

    assign cur_count  = count_reg[idx];
    assign cur_reload = reload_reg[idx];
    assign cur_ctrl   = ctrl_reg[idx];
    assign cur_accum  = accum_reg[idx];

    assign acc_sum  = cur_accum + ACC_W'(item_reg.cycles);
    assign shift    = prescale_shift(cur_ctrl[1:0]);
    assign cascaded = cur_ctrl[CTRL_CASC_BIT] && (t_reg != '0);
    assign to_wrap  = WRAP - {1'b0, cur_count};
    assign span     = WRAP - {1'b0, cur_reload};
    assign inc_wide = W1'(inc_reg);
    assign left     = inc_wide - to_wrap;
    assign left_n   = left[ACC_W-1:0];

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        t_next      = t_reg;
        inc_next    = inc_reg;
        below_next  = below_reg;
        irq_next    = irq_reg;
        q_pop       = 1'b0;
        div_req     = '0;
        count_we    = 1'b0;
        count_next  = cur_count;
        reload_we   = 1'b0;
        reload_next = cur_reload;
        ctrl_we     = 1'b0;
        ctrl_next   = cur_ctrl;
        accum_we    = 1'b0;
        accum_next  = cur_accum;
        finish      = 1'b0;
        advance     = 1'b0;
        out_load    = 1'b0;
        ovf         = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    irq_next   = '0;
                    below_next = '0;
                    t_next     = '0;
                    state_next = (q_item.op == OP_TICK) ? ST_INC : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // register writes; report beats fall through
                case (item_reg.op)
                    OP_RELOAD:
                    begin
                        reload_we   = 1'b1;
                        reload_next = item_reg.value;
                        count_we    = 1'b1;
                        count_next  = item_reg.value;
                    end
                    OP_CONTROL:
                    begin
                        ctrl_we   = 1'b1;
                        ctrl_next = item_reg.value[CTRL_W-1:0] & CTRL_MASK;
                        if (!cur_ctrl[CTRL_EN_BIT] && ctrl_next[CTRL_EN_BIT])
                        begin
                            count_we   = 1'b1;
                            count_next = cur_reload;
                            accum_we   = 1'b1;
                            accum_next = '0;
                        end
                        if (!ctrl_next[CTRL_EN_BIT])
                        begin
                            accum_we   = 1'b1;
                            accum_next = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                state_next = ST_DONE;
            end
            ST_INC:
            begin
                // number of increments for this timer
                if (!cur_ctrl[CTRL_EN_BIT])
                begin
                    below_next = '0;
                    advance    = 1'b1;
                end
                else if (cascaded)
                begin
                    inc_next   = below_reg;
                    state_next = ST_APPLY;
                end
                else
                begin
                    inc_next   = acc_sum >> shift;
                    accum_we   = 1'b1;
                    accum_next = acc_sum & ((ACC_W'(1) << shift) - ACC_W'(1));
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                // no overflow, a single overflow, or a run through the divider
                if (inc_wide < to_wrap)
                begin
                    count_we   = 1'b1;
                    count_next = cur_count + CNT_W'(inc_reg);
                    finish     = 1'b1;
                end
                else if (W1'(left_n) < span)
                begin
                    count_we   = 1'b1;
                    count_next = cur_reload + CNT_W'(left_n);
                    ovf        = ACC_W'(1);
                    finish     = 1'b1;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = left_n;
                    div_req.divisor  = span[ACC_W-1:0];
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    count_we   = 1'b1;
                    count_next = cur_reload + CNT_W'(div_rsp.rem);
                    ovf        = div_rsp.quot + ACC_W'(1);
                    finish     = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // close out a timer: pass overflows up the chain
        if (finish)
        begin
            below_next = ovf;
            if (ovf != '0 && cur_ctrl[CTRL_IRQ_BIT])
            begin
                irq_next[t_reg] = 1'b1;
            end
            advance = 1'b1;
        end

        // next timer or finish the tick
        if (advance)
        begin
            if (t_reg == SEL_W'(NUM_TIMERS - 1))
            begin
                state_next = ST_DONE;
            end
            else
            begin
                t_next     = t_reg + 1'b1;
                state_next = ST_INC;
            end
        end
    end

    // result valid
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    // control state and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            t_reg            <= '0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                count_reg[i]  <= '0;
                reload_reg[i] <= '0;
                ctrl_reg[i]   <= '0;
                accum_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            t_reg            <= t_next;
            result_valid_reg <= result_valid_next;
            if (count_we)
            begin
                count_reg[idx] <= count_next;
            end
            if (reload_we)
            begin
                reload_reg[idx] <= reload_next;
            end
            if (ctrl_we)
            begin
                ctrl_reg[idx] <= ctrl_next;
            end
            if (accum_we)
            begin
                accum_reg[idx] <= accum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        inc_reg   <= inc_next;
        below_reg <= below_next;
        irq_reg   <= irq_next;
        if (out_load)
        begin
            counter_value_reg <= item_reg.sel_ok ? cur_count : '0;
            control_value_reg <= item_reg.sel_ok ? (cur_ctrl & CTRL_MASK) : '0;
            irq_raised_reg    <= irq_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign counter_value = counter_value_reg;
    assign control_value = control_value_reg;
    assign irq_raised    = irq_raised_reg;

endmodule

`default_nettype wire

// File: rtl/cascaded_prescaled_timers.sv
// top level of the four-channel cascaded prescaled timer unit
// Input channel (item_valid / item_stall) carries one command beat: a tick with its
// cycle_count, a reload write or a control write to timer_select.
// Output channel (result_valid / result_stall) returns one beat per command:
// counter and control bits of the selected timer and the interrupts raised.
// A two-entry queue sits between the front end and the timer sequencer, so
// input beats are taken while the sequencer is busy or a result waits.
// From the queue, a write or report passes the execute and done states into
// the result register; a tick passes an increment and an apply state per
// enabled timer (only the increment state for a disabled one) before done.
// When a timer wraps more than once in a tick, the overflow count comes from
// a bit-serial divider, and the sequencer waits in its divide state for it.
// The sequencer takes the next command from the queue only when it has
// finished the last one and its result is loaded.
// Reset clears all counters, reload values, control words and accumulators,
// so every timer starts disabled; the queue and result register come up empty.
// A stalled result holds on the output; the sequencer then waits with the next
// result and the queue fills, after which item_stall is raised.
`default_nettype none

module cascaded_prescaled_timers (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic [cpt_pkg::CMD_W-1:0]  command,
    input  wire logic [cpt_pkg::SEL_W-1:0]  timer_select,
    input  wire logic [cpt_pkg::VAL_W-1:0]  write_value,
    input  wire logic [cpt_pkg::CYC_W-1:0]  cycle_count,
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [cpt_pkg::CNT_W-1:0]       counter_value,
    output logic [cpt_pkg::CTRL_W-1:0]      control_value,
    output logic [cpt_pkg::IRQ_W-1:0]       irq_raised
);
    import cpt_pkg::*;

    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    // classify and queue
    cpt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .timer_select (timer_select),
        .write_value  (write_value),
        .cycle_count  (cycle_count),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // overflow run divider
    cpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // timer state and sequencer
    cpt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .counter_value (counter_value),
        .control_value (control_value),
        .irq_raised    (irq_raised)
    );

    // divider is only started when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // divider completion is a single-cycle pulse
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |=> !div_rsp.done)
        else $error("divider done held for more than one cycle");

    // sequencer only pops a non-empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // an accepted beat is visible to the back end on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> q_valid)
        else $error("accepted beat missing from queue");

endmodule

`default_nettype wire

// File: bench/tb.sv
// self-checking testbench of the cascaded prescaled timer unit
`timescale 1ns / 1ps

module tb;

    import cpt_pkg::*;

    // command code that changes nothing and only reports
    localparam logic [CMD_W-1:0] CMD_REPORT_ONLY = 2'd3;

    localparam int NUM_DIRECTED = 25;
    localparam int RANDOM_ITEMS = 525;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // one result beat of the block
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic [CTRL_W-1:0] ctrl;
        logic [IRQ_W-1:0]  irq;
    } timer_report_t;

    // one row of the directed stimulus; known rows carry the result typed in
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SEL_W-1:0] sel;
        logic [VAL_W-1:0] value;
        logic [CYC_W-1:0] cycles;
        logic             known;
        timer_report_t    report;
    } stim_row_t;

    localparam timer_report_t NO_REPORT = '0;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // state right after reset, all-ones payload on the unused command
        '{CMD_REPORT_ONLY, 2'd0, 16'hFFFF, 7'd127, 1'b1, '{16'h0000, 8'h00, 4'h0}},
        // reload write sets counter too
        '{CMD_RELOAD,      2'd0, 16'hFFFF, 7'd0,   1'b1, '{16'hFFFF, 8'h00, 4'h0}},
        // control masked, cascade on timer 0 stored, enable loads reload
        '{CMD_CONTROL,     2'd0, 16'hFFFF, 7'd0,   1'b1, '{16'hFFFF, 8'hC7, 4'h0}},
        // long tick saturates to MAX_STEP_CYCLES, short of one count at the largest prescale
        '{CMD_TICK,        2'd0, 16'h0000, 7'd127, 1'b1, '{16'hFFFF, 8'hC7, 4'h0}},
        // prescale down to 1 while running keeps the accumulator
        '{CMD_CONTROL,     2'd0, 16'h00C0, 7'd0,   1'b1, '{16'hFFFF, 8'hC0, 4'h0}},
        // empty tick
        '{CMD_TICK,        2'd0, 16'h0000, 7'd0,   1'b1, '{16'hFFFF, 8'hC0, 4'h0}},
        // leftover accumulator spills over, every count wraps
        '{CMD_TICK,        2'd0, 16'h0000, 7'd1,   1'b1, '{16'hFFFF, 8'hC0, 4'h1}},
        // cascade chain across all four timers
        '{CMD_RELOAD,      2'd0, 16'hFFF0, 7'd0,   1'b0, NO_REPORT},
        '{CMD_RELOAD,      2'd1, 16'hFFFE, 7'd0,   1'b0, NO_REPORT},
        '{CMD_CONTROL,     2'd1, 16'h00C4, 7'd0,   1'b0, NO_REPORT},
        '{CMD_CONTROL,     2'd2, 16'h0084, 7'd0,   1'b0, NO_REPORT},
        '{CMD_RELOAD,      2'd3, 16'hFFFF, 7'd0,   1'b0, NO_REPORT},
        '{CMD_CONTROL,     2'd3, 16'h00C4, 7'd0,   1'b0, NO_REPORT},
        '{CMD_TICK,        2'd1, 16'h0000, 7'd64,  1'b0, NO_REPORT},
        '{CMD_TICK,        2'd3, 16'h0000, 7'd40,  1'b0, NO_REPORT},
        // disabled timer in the middle breaks the chain
        '{CMD_CONTROL,     2'd2, 16'h0004, 7'd0,   1'b0, NO_REPORT},
        '{CMD_TICK,        2'd3, 16'h0000, 7'd64,  1'b0, NO_REPORT},
        // disable then re-enable with prescale 64
        '{CMD_CONTROL,     2'd0, 16'h0041, 7'd0,   1'b0, NO_REPORT},
        '{CMD_CONTROL,     2'd0, 16'h0081, 7'd0,   1'b0, NO_REPORT},
        '{CMD_TICK,        2'd0, 16'h0000, 7'd63,  1'b0, NO_REPORT},
        // prescale up to 1024 while running
        '{CMD_CONTROL,     2'd0, 16'h0083, 7'd0,   1'b0, NO_REPORT},
        '{CMD_TICK,        2'd0, 16'h0000, 7'd64,  1'b0, NO_REPORT},
        '{CMD_CONTROL,     2'd1, 16'h0000, 7'd0,   1'b0, NO_REPORT},
        '{CMD_REPORT_ONLY, 2'd2, 16'h0000, 7'd0,   1'b0, NO_REPORT},
        '{CMD_TICK,        2'd0, 16'h0000, 7'h55,  1'b0, NO_REPORT}
    };

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_stall;
    logic [CMD_W-1:0]  command;
    logic [SEL_W-1:0]  timer_select;
    logic [VAL_W-1:0]  write_value;
    logic [CYC_W-1:0]  cycle_count;
    logic              result_valid;
    logic              result_stall;
    logic [CNT_W-1:0]  counter_value;
    logic [CTRL_W-1:0] control_value;
    logic [IRQ_W-1:0]  irq_raised;

    // predicted timer state
    logic [CNT_W-1:0]  timer_count  [SLOTS];
    logic [VAL_W-1:0]  timer_reload [SLOTS];
    logic [CTRL_W-1:0] timer_ctrl   [SLOTS];
    logic [ACC_W-1:0]  timer_accum  [SLOTS];

    timer_report_t expected_reports [$];
    timer_report_t oldest_report;

    int fail_count   = 0;
    int cycle_total  = 0;
    int burst_left   = 0;
    int tick_beats   = 0;
    int write_beats  = 0;
    int result_beats = 0;
    int irq_beats    = 0;

    cascaded_prescaled_timers DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .timer_select  (timer_select),
        .write_value   (write_value),
        .cycle_count   (cycle_count),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .counter_value (counter_value),
        .control_value (control_value),
        .irq_raised    (irq_raised)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // prescale select to cycles per count
    function automatic int prescale_cycles(input logic [1:0] ps);
        case (ps)
            2'd0:    return 1;
            2'd1:    return 64;
            2'd2:    return 256;
            default: return 1024;
        endcase
    endfunction

    // count one timer forward, return how often it wrapped
    function automatic int advance_timer(input int t, input int cycles, input int below);
        logic [CTRL_W-1:0] ctrl;
        int steps;
        int span;
        int total;
        int wraps;
        ctrl  = timer_ctrl[t];
        wraps = 0;
        if (!ctrl[CTRL_EN_BIT])
            return 0;
        if (t > 0 && ctrl[CTRL_CASC_BIT])
            steps = below;
        else
        begin
            span  = prescale_cycles(ctrl[1:0]);
            total = int'(timer_accum[t]) + cycles;
            steps = total / span;
            timer_accum[t] = ACC_W'(total % span);
        end
        for (int i = 0; i < steps; i++)
        begin
            if (timer_count[t] == {CNT_W{1'b1}})
            begin
                timer_count[t] = timer_reload[t];
                wraps++;
            end
            else
                timer_count[t] = timer_count[t] + 1'b1;
        end
        return wraps;
    endfunction

    // apply one command beat to the predicted state, return its report
    function automatic timer_report_t apply_command(input logic [CMD_W-1:0] cmd,
                                                    input logic [SEL_W-1:0] sel,
                                                    input logic [VAL_W-1:0] val,
                                                    input logic [CYC_W-1:0] cyc);
        timer_report_t     rep;
        logic              sel_ok;
        logic              was_on;
        logic [CTRL_W-1:0] new_ctrl;
        int                cycles;
        int                carry;
        rep    = '0;
        sel_ok = int'(sel) < NUM_TIMERS;
        case (cmd)
            CMD_TICK:
            begin
                cycles = (int'(cyc) > MAX_STEP_CYCLES) ? MAX_STEP_CYCLES : int'(cyc);
                carry  = 0;
                if (cycles != 0)
                begin
                    for (int t = 0; t < NUM_TIMERS; t++)
                    begin
                        carry = advance_timer(t, cycles, carry);
                        if (carry != 0 && timer_ctrl[t][CTRL_IRQ_BIT])
                            rep.irq[t] = 1'b1;
                    end
                end
            end
            CMD_RELOAD:
            begin
                if (sel_ok)
                begin
                    timer_reload[sel] = val;
                    timer_count[sel]  = val;
                end
            end
            CMD_CONTROL:
            begin
                if (sel_ok)
                begin
                    was_on   = timer_ctrl[sel][CTRL_EN_BIT];
                    new_ctrl = val[CTRL_W-1:0] & CTRL_MASK;
                    timer_ctrl[sel] = new_ctrl;
                    if (!was_on && new_ctrl[CTRL_EN_BIT])
                    begin
                        timer_count[sel] = timer_reload[sel];
                        timer_accum[sel] = '0;
                    end
                    if (!new_ctrl[CTRL_EN_BIT])
                        timer_accum[sel] = '0;
                end
            end
            default:
            begin
            end
        endcase
        if (sel_ok)
        begin
            rep.count = timer_count[sel];
            rep.ctrl  = timer_ctrl[sel] & CTRL_MASK;
        end
        return rep;
    endfunction

    // drive one command beat, wait for it to be taken, queue its report
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                                input logic [VAL_W-1:0] val, input logic [CYC_W-1:0] cyc,
                                input logic known, input timer_report_t typed);
        timer_report_t rep;
        item_valid   <= 1'b1;
        command      <= cmd;
        timer_select <= sel;
        write_value  <= val;
        cycle_count  <= cyc;
        do
            @(posedge clk);
        while (item_stall);
        rep = apply_command(cmd, sel, val, cyc);
        expected_reports.push_back(known ? typed : rep);
        if (cmd == CMD_TICK)
            tick_beats++;
        else if (cmd != CMD_REPORT_ONLY)
            write_beats++;
    endtask

    // bursts of random length with random gaps in between
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver stall pattern, changing its mode after each run of random length
    initial
    begin
        int stall_mode;
        int stall_left;
        stall_mode   = 0;
        stall_left   = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 80);
            end
            stall_left--;
            case (stall_mode)
                0:       result_stall <= 1'b0;
                1:       result_stall <= ($urandom_range(0, 3) == 0);
                2:       result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ((stall_left % 8) < 5);
            endcase
        end
    end

    // compare each taken result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            result_beats++;
            if (irq_raised != '0)
                irq_beats++;
            if (expected_reports.size() == 0)
            begin
                $error("result beat with no prediction pending");
                fail_count++;
            end
            else
            begin
                oldest_report = expected_reports.pop_front();
                if (counter_value !== oldest_report.count)
                begin
                    $error("counter_value expected %h actual %h",
                           oldest_report.count, counter_value);
                    fail_count++;
                end
                if (control_value !== oldest_report.ctrl)
                begin
                    $error("control_value expected %h actual %h",
                           oldest_report.ctrl, control_value);
                    fail_count++;
                end
                if (irq_raised !== oldest_report.irq)
                begin
                    $error("irq_raised expected %h actual %h",
                           oldest_report.irq, irq_raised);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_total < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_total++;
        end
        $display("timeout after %0d cycles", cycle_total);
        $display("simulation failed");
        $finish;
    end

    // reset, directed table, random traffic, drain
    initial
    begin
        logic [CMD_W-1:0] cmd;
        logic [SEL_W-1:0] sel;
        logic [VAL_W-1:0] val;
        logic [CYC_W-1:0] cyc;
        int               pick;

        rst_n        = 1'b0;
        item_valid   = 1'b0;
        command      = CMD_TICK;
        timer_select = '0;
        write_value  = '0;
        cycle_count  = '0;
        for (int t = 0; t < SLOTS; t++)
        begin
            timer_count[t]  = '0;
            timer_reload[t] = '0;
            timer_ctrl[t]   = '0;
            timer_accum[t]  = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].sel, DIRECTED_ROWS[r].value,
                         DIRECTED_ROWS[r].cycles, DIRECTED_ROWS[r].known,
                         DIRECTED_ROWS[r].report);
            pace_sender();
        end

        // random traffic, weighted toward overflow-heavy timer setups
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            sel  = SEL_W'($urandom_range(0, SLOTS - 1));
            val  = VAL_W'($urandom);
            cyc  = CYC_W'($urandom_range(1, MAX_STEP_CYCLES));
            if (pick < 50)
            begin
                cmd = CMD_TICK;
                if ($urandom_range(0, 9) == 0)
                    cyc = CYC_W'($urandom_range(0, (1 << CYC_W) - 1));
            end
            else if (pick < 70)
            begin
                cmd = CMD_RELOAD;
                if ($urandom_range(0, 2) != 0)
                    val[VAL_W-1:8] = '1;
            end
            else if (pick < 95)
            begin
                cmd = CMD_CONTROL;
                if ($urandom_range(0, 3) != 0)
                    val[CTRL_EN_BIT] = 1'b1;
            end
            else
                cmd = CMD_REPORT_ONLY;
            send_command(cmd, sel, val, cyc, 1'b0, NO_REPORT);

            // hold off once until the block has answered everything
            if (n == RANDOM_ITEMS / 2)
            begin
                item_valid <= 1'b0;
                while (expected_reports.size() != 0)
                    @(posedge clk);
            end
            else
                pace_sender();
        end

        // drain
        item_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d beats: %0d ticks, %0d register writes",
                 NUM_DIRECTED + RANDOM_ITEMS, tick_beats, write_beats);
        $display("checked %0d result beats, %0d of them with interrupts, %0d mismatches",
                 result_beats, irq_beats, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/cpt_pkg.sv
rtl/cpt_front.sv
rtl/cpt_div.sv
rtl/cpt_back.sv
rtl/cascaded_prescaled_timers.sv
bench/tb.sv
